>>> rtl/rr_pkg.sv
package rr_pkg;

   localparam int WIDTH = 32;
   // wide enough for a shift count or bit index up to WIDTH-1
   localparam int KW    = $clog2(WIDTH);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [WIDTH-1:0] num_in;
      logic signed [WIDTH-1:0] den_in;
   } req_type;

   typedef struct packed {
      logic signed [WIDTH-1:0] num_out;
      logic [WIDTH-2:0]        den_out;
      logic [1:0]              status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture operands, start gcd
      logic gcd_step;    // one binary gcd step
      logic shift_step;  // restore one common factor of two
      logic div_init;    // load divider
      logic div_sel_d;   // divider dividend: 0 numerator, 1 denominator
      logic div_step;    // one restoring divide step
      logic save_rn;     // keep numerator quotient
      logic out_load;    // write result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic special;     // zero numerator or zero denominator
      logic gcd_done;    // u and v equal
      logic k_zero;      // no factor of two left to restore
      logic div_last;    // final divide step
   } stat_type;

endpackage

>>> rtl/rr_dpath.sv
module rr_dpath import rr_pkg::*; (
   input  logic     clock,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   logic [WIDTH-1:0] an_ff, an_in;
   logic [WIDTH-1:0] ad_ff, ad_in;
   logic             neg_ff, neg_in;
   logic [WIDTH-1:0] u_ff, u_in;
   logic [WIDTH-1:0] v_ff, v_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [KW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rn_ff, rn_in;
   rsp_type          out_ff, out_in;

   logic [WIDTH-1:0] n_raw, d_raw;
   logic [WIDTH:0]   shifted, trial;
   logic [WIDTH-1:0] rn_neg;
   logic             ovf;

   assign n_raw = req_data.num_in;
   assign d_raw = req_data.den_in;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign trial   = shifted - {1'b0, u_ff};
   assign rn_neg  = ~rn_ff + 1'b1;
   // quo_ff holds the reduced denominator when the result is written
   assign ovf     = quo_ff[WIDTH-1] | (!neg_ff & rn_ff[WIDTH-1]);

   assign stat.special  = (an_ff == '0) || (ad_ff == '0);
   assign stat.gcd_done = (u_ff == v_ff);
   assign stat.k_zero   = (k_ff == '0);
   assign stat.div_last = (cnt_ff == KW'(WIDTH-1));

   assign rsp_data = out_ff;

   always_comb begin
      an_in  = an_ff;
      ad_in  = ad_ff;
      neg_in = neg_ff;
      u_in   = u_ff;
      v_in   = v_ff;
      k_in   = k_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      rn_in  = rn_ff;
      out_in = out_ff;

      if (cmd.load) begin
         an_in  = n_raw[WIDTH-1] ? (~n_raw + 1'b1) : n_raw;
         ad_in  = d_raw[WIDTH-1] ? (~d_raw + 1'b1) : d_raw;
         neg_in = n_raw[WIDTH-1] ^ d_raw[WIDTH-1];
         u_in   = n_raw[WIDTH-1] ? (~n_raw + 1'b1) : n_raw;
         v_in   = d_raw[WIDTH-1] ? (~d_raw + 1'b1) : d_raw;
         k_in   = '0;
      end

      if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff > v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end

      if (cmd.shift_step) begin
         u_in = u_ff << 1;
         k_in = k_ff - 1'b1;
      end

      if (cmd.save_rn) begin
         rn_in = quo_ff;
      end

      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = cmd.div_sel_d ? ad_ff : an_ff;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.out_load) begin
         out_in = '0;
         if (ad_ff == '0) begin
            out_in.status = ST_ZERO_DEN;
         end else if (an_ff == '0) begin
            out_in.den_out = (WIDTH-1)'(1);
         end else if (ovf) begin
            out_in.status = ST_OVERFLOW;
         end else begin
            out_in.num_out = neg_ff ? rn_neg : rn_ff;
            out_in.den_out = quo_ff[WIDTH-2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      an_ff  <= an_in;
      ad_ff  <= ad_in;
      neg_ff <= neg_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      k_ff   <= k_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rn_ff  <= rn_in;
      out_ff <= out_in;
   end

endmodule

>>> rtl/rr_ctrl.sv
module rr_ctrl import rr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GCD   = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_DIVN  = 3'd3;
   localparam logic [2:0] S_SAVEN = 3'd4;
   localparam logic [2:0] S_DIVD  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.special) begin
               state_in = S_FIN;
            end else if (stat.gcd_done) begin
               state_in = S_SHIFT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.k_zero) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIVN;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_SAVEN;
            end
         end
         S_SAVEN: begin
            cmd.save_rn   = 1'b1;
            cmd.div_init  = 1'b1;
            cmd.div_sel_d = 1'b1;
            state_in      = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/rational_reduce.sv
// rational_reduce: reduces a signed fraction num_in/den_in to lowest terms.
// Both magnitudes are divided by their greatest common divisor and the sign
// of the fraction is moved onto num_out, so den_out is positive on status 0.
// A zero numerator over a nonzero denominator returns 0/1. A zero
// denominator returns status 1 with zero outputs; a result that does not
// fit (e.g. most negative over -1, or 1 over the most negative value)
// returns status 2 with zero outputs. One item is in work at a time.
// An item with a zero operand goes from the gcd state straight to the
// result write; otherwise it runs the binary gcd steps, one restore step
// per common factor of two, and two restoring divisions that share one
// divider, one quotient bit per cycle. The result sits in an output
// register, so a new request transfer is taken while a finished result
// still waits.
module rational_reduce import rr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: gcd loop, factor-of-two restore, two divides, result write
   rr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // magnitudes, binary gcd registers, shared divider, result register
   rr_dpath u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> dv/testbench.sv
module testbench import rr_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic signed [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};
   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_PER_PHASE = 600;
   // extra wait at the end, after every result is back, so that a stray
   // late result would still be caught
   localparam int DRAIN_CYCLES = 400;

   // all inputs start at known values
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // fractions waiting to be offered, and reduced results owed by the block
   req_type fractions_to_send[$];
   rsp_type reduced_fractions_due[$];

   int send_gap_pct = 0;     // chance per cycle that the sender holds off
   int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   int fractions_queued = 0;
   int fractions_taken = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int random_count = 0;
   int seen_ok = 0;
   int seen_zero_den = 0;
   int seen_overflow = 0;

   rational_reduce dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Golden reduction: magnitudes by Euclid, sign moved onto the numerator.
   // Work is done in 64 bits with everything above WIDTH masked off.
   function automatic rsp_type reduce_fraction(req_type frac);
      logic [63:0] keep, sign_pos, num_bits, den_bits, num_mag, den_mag;
      logic [63:0] x, y, rem, num_red, den_red, signed_num;
      logic        flip;
      rsp_type     res;
      keep = {64{1'b1}} >> (64 - WIDTH);
      sign_pos = 64'd1 << (WIDTH - 1);
      num_bits = '0;
      den_bits = '0;
      num_bits[WIDTH-1:0] = frac.num_in;
      den_bits[WIDTH-1:0] = frac.den_in;
      res = '0;
      if (den_bits == 0) begin
         res.status = ST_ZERO_DEN;
      end else if (num_bits == 0) begin
         res.den_out = (WIDTH-1)'(1);
      end else begin
         num_mag = num_bits[WIDTH-1] ? ((~num_bits + 64'd1) & keep) : num_bits;
         den_mag = den_bits[WIDTH-1] ? ((~den_bits + 64'd1) & keep) : den_bits;
         x = num_mag;
         y = den_mag;
         while (y != 0) begin
            rem = x % y;
            x = y;
            y = rem;
         end
         num_red = num_mag / x;
         den_red = den_mag / x;
         flip = num_bits[WIDTH-1] ^ den_bits[WIDTH-1];
         // reduced form must fit: den below 2^(W-1), positive num likewise
         if (den_red >= sign_pos || (!flip && num_red >= sign_pos)) begin
            res.status = ST_OVERFLOW;
         end else begin
            signed_num = flip ? (~num_red + 64'd1) : num_red;
            res.num_out = signed_num[WIDTH-1:0];
            res.den_out = den_red[WIDTH-2:0];
         end
      end
      return res;
   endfunction

   function automatic logic signed [WIDTH-1:0] random_sign(logic signed [WIDTH-1:0] mag);
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // corner values of a signed operand
   function automatic logic signed [WIDTH-1:0] corner_value();
      case ($urandom_range(5))
         0: return MOST_NEG;
         1: return MOST_NEG + 1;
         2: return MOST_POS;
         3: return 1;
         4: return -1;
         default: return 0;
      endcase
   endfunction

   // operand of random size: small values are where reduction gets busy
   function automatic logic signed [WIDTH-1:0] sized_value();
      logic [WIDTH-1:0] mag;
      mag = $urandom;
      return random_sign(mag >> $urandom_range(WIDTH - 1));
   endfunction

   // Random mix: raw bit patterns, fractions built around a shared factor,
   // powers of two (long runs of common twos), zero operands, corners and sized values.
   function automatic req_type random_fraction();
      req_type          frac;
      logic [WIDTH-1:0] factor, p, q;
      case ($urandom_range(9))
         0, 1: begin
            frac.num_in = $urandom;
            frac.den_in = $urandom;
         end
         2, 3, 4: begin
            factor = ($urandom >> $urandom_range(17, WIDTH - 1)) + 1;
            p = $urandom >> $urandom_range(16, WIDTH - 1);
            q = $urandom >> $urandom_range(16, WIDTH - 1);
            frac.num_in = random_sign(p * factor);
            frac.den_in = random_sign(q * factor);
         end
         5: begin
            p = 1;
            q = 1;
            frac.num_in = random_sign(p << $urandom_range(WIDTH - 1));
            frac.den_in = random_sign(q << $urandom_range(WIDTH - 1));
         end
         6: begin
            frac.num_in = sized_value();
            frac.den_in = sized_value();
            case ($urandom_range(2))
               0: frac.num_in = 0;
               1: frac.den_in = 0;
               default: begin
                  frac.num_in = 0;
                  frac.den_in = 0;
               end
            endcase
         end
         7: begin
            frac.num_in = corner_value();
            frac.den_in = $urandom_range(1) ? corner_value() : sized_value();
         end
         default: begin
            frac.num_in = sized_value();
            frac.den_in = sized_value();
         end
      endcase
      return frac;
   endfunction

   function automatic void queue_fraction(logic signed [WIDTH-1:0] n,
                                          logic signed [WIDTH-1:0] d);
      req_type frac;
      frac.num_in = n;
      frac.den_in = d;
      fractions_to_send.push_back(frac);
      fractions_queued++;
   endfunction

   // Request driver. A new fraction is offered only when the channel is free
   // (nothing shown, or the shown one transferred this edge); a stalled
   // payload is held untouched. Expectations are logged at the transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            reduced_fractions_due.push_back(reduce_fraction(req_data));
            fractions_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (fractions_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data <= fractions_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer against the oldest expectation,
   // then picks the stall for the next cycle.
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reduced_fractions_due.size() == 0) begin
               $error("transfer with nothing outstanding: num_out %0d den_out %0d status %0d",
                      rsp_data.num_out, rsp_data.den_out, rsp_data.status);
               mismatch_count++;
            end else begin
               due = reduced_fractions_due.pop_front();
               results_checked++;
               case (due.status)
                  ST_OK:       seen_ok++;
                  ST_ZERO_DEN: seen_zero_den++;
                  default:     seen_overflow++;
               endcase
               if (rsp_data.num_out !== due.num_out) begin
                  $error("num_out: expected %0d, got %0d", due.num_out, rsp_data.num_out);
                  mismatch_count++;
               end
               if (rsp_data.den_out !== due.den_out) begin
                  $error("den_out: expected %0d, got %0d", due.den_out, rsp_data.den_out);
                  mismatch_count++;
               end
               if (rsp_data.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_data.status);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Blocks until every queued fraction has transferred and every result
   // has come back. Sampled mid-cycle so driver updates have settled.
   task automatic drain();
      @(negedge clock);
      while (fractions_taken != fractions_queued || reduced_fractions_due.size() != 0)
         @(negedge clock);
   endtask

   // Stimulus sequencer: directed corners, then three random phases with
   // different idle mixes. Each phase boundary leaves the sender quiet until
   // the block has answered everything, which doubles as the pressure check.
   initial begin
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 14;
      recv_stall_pct = 56;
      @(negedge clock);
      // zero operands
      queue_fraction(0, 1);
      queue_fraction(0, -5);
      queue_fraction(5, 0);
      queue_fraction(0, 0);
      queue_fraction(MOST_NEG, 0);
      // unrepresentable results
      queue_fraction(MOST_NEG, -1);
      queue_fraction(MOST_NEG, -3);
      queue_fraction(1, MOST_NEG);
      queue_fraction(-1, MOST_NEG);
      // both most negative reduces to 1/1
      queue_fraction(MOST_NEG, MOST_NEG);
      queue_fraction(MOST_NEG, 1);
      queue_fraction(MOST_NEG, 2);
      queue_fraction(2, MOST_NEG);
      queue_fraction(MOST_POS, MOST_POS);
      queue_fraction(MOST_POS, -1);
      queue_fraction(MOST_POS, MOST_NEG);
      queue_fraction(MOST_NEG + 1, -1);
      // sign placement
      queue_fraction(-6, 4);
      queue_fraction(6, -4);
      queue_fraction(-6, -4);
      queue_fraction(12, 18);
      queue_fraction(1 << 30, 1 << 20);
      queue_fraction(7, 13);
      queue_fraction(-1, -1);
      drain();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 14;
               recv_stall_pct = 56;
            end
            1: begin
               send_gap_pct = 56;
               recv_stall_pct = 14;
            end
            default: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            fractions_to_send.push_back(random_fraction());
            fractions_queued++;
            random_count++;
         end
         drain();
      end

      // catch any stray late result
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random fractions, %0d results checked",
               DIRECTED_COUNT, random_count, results_checked);
      $display("status mix: %0d reduced, %0d zero denominator, %0d unrepresentable",
               seen_ok, seen_zero_den, seen_overflow);
      if (mismatch_count == 0 && reduced_fractions_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #60_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
rtl/rr_pkg.sv
rtl/rr_dpath.sv
rtl/rr_ctrl.sv
rtl/rational_reduce.sv
dv/testbench.sv
